@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, idle while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ sv/mcae_pkg.sv @@
// ----------------------------------------------------------------------------
// mcae_pkg
// Types, constants and the colour formatter of the cursor expander.
// ----------------------------------------------------------------------------
package mcae_pkg;

  localparam int PIXELS_PER_WORD = 32;
  localparam int WORD_W          = 32;
  localparam int RGB_W           = 24;
  localparam int PIXEL_W         = 32;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MODE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MSB_FIRST  = CFG_IDX_W'(3);

  localparam logic [RGB_W-1:0] FG_COLOR_RESET = 24'hffffff;
  localparam logic [RGB_W-1:0] BG_COLOR_RESET = 24'h000000;

  localparam logic [PIXEL_W-1:0] ALPHA_8888 = 32'hff000000;
  localparam logic [PIXEL_W-1:0] ALPHA_1555 = 32'h00008000;

  // One bit position of the cursor word as it moves along the row.
  typedef struct packed {
    logic valid;
    logic src;
    logic msk;
    logic last;
  } cell_data_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Pre-formatted colours and bit order from the register file.
  typedef struct packed {
    logic [PIXEL_W-1:0] fore;
    logic [PIXEL_W-1:0] back;
    logic               msb_first;
  } cfg_fmt_t;

  function automatic logic [PIXEL_W-1:0] format_colour(input logic [RGB_W-1:0] rgb,
                                                       input logic alpha_mode);
    logic [PIXEL_W-1:0] px;
    if (alpha_mode) begin
      px = ALPHA_8888 | PIXEL_W'(rgb);
    end else begin
      px = ALPHA_1555 | PIXEL_W'({rgb[23:19], rgb[15:11], rgb[7:3]});
    end
    return px;
  endfunction

endpackage

@@ sv/mcae_if.sv @@
// ----------------------------------------------------------------------------
// mcae_if
// Valid/ready channels of the cursor expander: input, result, configuration.
// ----------------------------------------------------------------------------
interface mcae_in_if import mcae_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] source_bits;
  logic [WORD_W-1:0] mask_bits;
  modport source (output valid, source_bits, mask_bits, input ready);
  modport sink   (input valid, source_bits, mask_bits, output ready);
endinterface

interface mcae_out_if import mcae_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               last;
  modport source (output valid, pixel, last, input ready);
  modport sink   (input valid, pixel, last, output ready);
endinterface

interface mcae_cfg_if import mcae_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/mcae_cell.sv @@
// ----------------------------------------------------------------------------
// mcae_cell
// One bit position of the shift row: load in parallel or take the neighbour.
// ----------------------------------------------------------------------------
module mcae_cell import mcae_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_data_t ld_data,
  input  cell_data_t nb_data,
  output cell_data_t data_o
);

  cell_data_t data_r;
  cell_data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctrl.load) begin
      data_nxt = ld_data;
    end else if (ctrl.shift) begin
      data_nxt = nb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else begin
      data_r.valid <= data_nxt.valid;
    end
    data_r.src  <= data_nxt.src;
    data_r.msk  <= data_nxt.msk;
    data_r.last <= data_nxt.last;
  end

  assign data_o = data_r;

endmodule

@@ sv/mcae_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mcae_cfg_regs
// Register file; formats both colours for the output stage.
// ----------------------------------------------------------------------------
module mcae_cfg_regs import mcae_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  mcae_cfg_if.sink    cfg_ch,
  output cfg_fmt_t    fmt
);

  logic [RGB_W-1:0] fg_color_r, fg_color_nxt;
  logic [RGB_W-1:0] bg_color_r, bg_color_nxt;
  logic             alpha_mode_r, alpha_mode_nxt;
  logic             msb_first_r, msb_first_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    fg_color_nxt   = fg_color_r;
    bg_color_nxt   = bg_color_r;
    alpha_mode_nxt = alpha_mode_r;
    msb_first_nxt  = msb_first_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_FG_COLOR:   fg_color_nxt   = cfg_ch.data[RGB_W-1:0];
        REG_BG_COLOR:   bg_color_nxt   = cfg_ch.data[RGB_W-1:0];
        REG_ALPHA_MODE: alpha_mode_nxt = cfg_ch.data[0];
        REG_MSB_FIRST:  msb_first_nxt  = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_color_r   <= FG_COLOR_RESET;
      bg_color_r   <= BG_COLOR_RESET;
      alpha_mode_r <= 1'b1;
      msb_first_r  <= 1'b0;
    end else begin
      fg_color_r   <= fg_color_nxt;
      bg_color_r   <= bg_color_nxt;
      alpha_mode_r <= alpha_mode_nxt;
      msb_first_r  <= msb_first_nxt;
    end
  end

  assign fmt.fore      = format_colour(fg_color_r, alpha_mode_r);
  assign fmt.back      = format_colour(bg_color_r, alpha_mode_r);
  assign fmt.msb_first = msb_first_r;

endmodule

@@ sv/mono_cursor_to_argb_expander.sv @@
// ----------------------------------------------------------------------------
// mono_cursor_to_argb_expander
// Expands one source/mask word pair into a run of formatted cursor pixels.
// ----------------------------------------------------------------------------
//  channel | dir | transaction
//  in_ch   | in  | source_bits, mask_bits: one cursor word pair
//  out_ch  | out | pixel, last: one formatted pixel, last on the final one
//  cfg_ch  | in  | index, data: one register write, always ready
//
//  One pixel leaves the head cell of the shift row per cycle while out_ch is
//  not stalled, and the next word loads as the final pixel leaves, so words
//  follow each other without a gap.
//  Reset clears the cell valid bits, the output valid bit and the registers.
//  A stall on out_ch freezes the whole row and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mono_cursor_to_argb_expander import mcae_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  mcae_in_if.sink   in_ch,
  mcae_out_if.source out_ch,
  mcae_cfg_if.sink  cfg_ch
);

  cfg_fmt_t   fmt;
  cell_ctrl_t ctrl;
  cell_data_t ld_data [PIXELS_PER_WORD];
  cell_data_t cell_q  [PIXELS_PER_WORD];
  logic [PIXELS_PER_WORD-1:0] vld;

  logic               advance;
  logic               in_fire;
  logic               out_valid_r, out_valid_nxt;
  logic [PIXEL_W-1:0] pixel_r, pixel_nxt;
  logic               last_r, last_nxt;
  logic               head_last;
  logic               tail_last;

  mcae_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .fmt    (fmt)
  );

  // Advance the row whenever the output register is free or being drained.
  assign advance = !out_valid_r || out_ch.ready;
  // Take a new word once at most the head cell is left and the row advances now.
  assign in_ch.ready = advance && !cell_q[1].valid;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign ctrl.load  = in_fire;
  assign ctrl.shift = advance;

  for (genvar k = 0; k < PIXELS_PER_WORD; k++) begin : g_row
    // Cell k holds the k-th pixel of the word in output order.
    assign ld_data[k].valid = 1'b1;
    assign ld_data[k].src   = fmt.msb_first ? in_ch.source_bits[WORD_W-1-k]
                                            : in_ch.source_bits[k];
    assign ld_data[k].msk   = fmt.msb_first ? in_ch.mask_bits[WORD_W-1-k]
                                            : in_ch.mask_bits[k];
    assign ld_data[k].last  = (k == PIXELS_PER_WORD - 1);

    if (k == PIXELS_PER_WORD - 1) begin : g_tail
      mcae_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .ld_data (ld_data[k]),
        .nb_data ('0),
        .data_o  (cell_q[k])
      );
    end else begin : g_body
      mcae_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .ld_data (ld_data[k]),
        .nb_data (cell_q[k+1]),
        .data_o  (cell_q[k])
      );
    end
    assign vld[k] = cell_q[k].valid;
  end

  // Output register: format the head cell as it leaves the row.
  always_comb begin
    out_valid_nxt = out_valid_r;
    pixel_nxt     = pixel_r;
    last_nxt      = last_r;
    if (advance) begin
      out_valid_nxt = cell_q[0].valid;
      last_nxt      = cell_q[0].last;
      if (!cell_q[0].msk) begin
        pixel_nxt = '0;
      end else if (cell_q[0].src) begin
        pixel_nxt = fmt.fore;
      end else begin
        pixel_nxt = fmt.back;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    pixel_r <= pixel_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pixel = pixel_r;
  assign out_ch.last  = last_r;

  assign head_last = cell_q[0].valid && cell_q[0].last;
  assign tail_last = vld[PIXELS_PER_WORD-1] && cell_q[PIXELS_PER_WORD-1].last;

  // A loaded word fills the row right up to the tail cell.
  `ASSERT_PROP(a_load_fills_row, in_fire |=> tail_last, "word load did not reach the tail cell")
  // Occupied cells always form one run from the head.
  `ASSERT_NEVER(a_row_contiguous, ((vld & (vld + PIXELS_PER_WORD'(1))) != '0), "gap in row")
  // The final pixel of a word sits alone in the row.
  `ASSERT_PROP(a_last_alone, head_last |-> ($countones(vld) == 1), "last pixel not alone")

endmodule
